@@ design/itad_pkg.sv @@
// itad_pkg: shared types and constants for the integer to ascii converter
// no dependencies; imported by itad_digit_unit, integer_to_ascii_dec_hex and tb
`default_nettype none

package itad_pkg;

   localparam int NumDigits  = 20;
   localparam int DigitWidth = 4;
   localparam int DigWidth   = NumDigits * DigitWidth;
   localparam int ValWidth   = 64;
   localparam int CntWidth   = 5;

   localparam logic [1:0] ACT_UDEC   = 2'd0;
   localparam logic [1:0] ACT_SDEC   = 2'd1;
   localparam logic [1:0] ACT_HEXMIN = 2'd2;
   localparam logic [1:0] ACT_HEX16  = 2'd3;

   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_LOAD_DEC,
      CMD_LOAD_HEX,
      CMD_DABBLE,
      CMD_SHIFT
   } itad_cmd_type;

   typedef struct packed {
      itad_cmd_type          op;
      logic [ValWidth-1:0]   data;
   } itad_ctl_type;

   typedef struct packed {
      logic [DigitWidth-1:0] top_digit;
      logic                  top_zero;
   } itad_stat_type;

   // lowercase hex digit set
   function automatic logic [7:0] digit_char(input logic [DigitWidth-1:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = 8'h57 + {4'd0, d};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ design/itad_digit_unit.sv @@
// itad_digit_unit: 20-digit register with a per-digit shift-and-add-3 step
// depends on itad_pkg; driven by the sequencer in integer_to_ascii_dec_hex
`default_nettype none

module itad_digit_unit
   import itad_pkg::*;
(
   input  logic          clock,
   input  itad_ctl_type  ctl,
   output itad_stat_type stat
);

   logic [DigWidth-1:0] dig_ff, dig_in;
   logic [ValWidth-1:0] bin_ff, bin_in;
   logic [DigWidth-1:0] adj;

   // add 3 to every digit of 5 or more before the doubling shift
   always_comb begin
      for (int i = 0; i < NumDigits; i++) begin
         if (dig_ff[i*DigitWidth +: DigitWidth] >= 4'd5) begin
            adj[i*DigitWidth +: DigitWidth] = dig_ff[i*DigitWidth +: DigitWidth] + 4'd3;
         end else begin
            adj[i*DigitWidth +: DigitWidth] = dig_ff[i*DigitWidth +: DigitWidth];
         end
      end
   end

   always_comb begin
      dig_in = dig_ff;
      bin_in = bin_ff;
      unique case (ctl.op)
         CMD_HOLD: begin
         end
         CMD_LOAD_DEC: begin
            dig_in = '0;
            bin_in = ctl.data;
         end
         CMD_LOAD_HEX: begin
            dig_in = {{(DigWidth-ValWidth){1'b0}}, ctl.data};
         end
         CMD_DABBLE: begin
            dig_in = {adj[DigWidth-2:0], bin_ff[ValWidth-1]};
            bin_in = {bin_ff[ValWidth-2:0], 1'b0};
         end
         CMD_SHIFT: begin
            dig_in = {dig_ff[DigWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      dig_ff <= dig_in;
      bin_ff <= bin_in;
   end

   assign stat.top_digit = dig_ff[DigWidth-1 -: DigitWidth];
   assign stat.top_zero  = (dig_ff[DigWidth-1 -: DigitWidth] == '0);

endmodule

`default_nettype wire

@@ design/integer_to_ascii_dec_hex.sv @@
// integer_to_ascii_dec_hex: top level, sequencer and output register
// depends on itad_pkg and itad_digit_unit
//
// Usage: one number is taken on the req_ channel (req_value, req_action,
// req_wide) and leaves as ASCII characters on the rsp_ channel, most
// significant first, rsp_last_char high on the final one.
// Decimal modes convert with a shift-and-add-3 step, one operand bit a
// cycle, over 32 bits for a narrow operand and 64 for a wide one. Hex
// modes load the digit register directly. Leading zero digits are then
// dropped at one per cycle (up to 19, exactly 4 for sixteen-digit hex),
// the first digit is found, then a minus sign goes out if the number is
// negative, then each character, waiting while the receiver stalls.
// The next number can be taken in the cycle after the last character has
// entered the output register. req_ready is low from acceptance until the
// last character has entered the output register, so one number is in work
// at a time.
// The output register holds a character until rsp_ready takes it; while
// the receiver stalls the sequencer waits. A finished character may still
// wait there while the next number is accepted.
// Reset (synchronous) empties the output register and returns to idle.
`default_nettype none

module integer_to_ascii_dec_hex
   import itad_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ValWidth-1:0] req_value,
   input  logic [1:0]          req_action,
   input  logic                req_wide,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_last_char
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [5:0]          iter_ff, iter_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [CntWidth-1:0] keep_ff, keep_in;
   logic                neg_ff, neg_in;
   logic                hex_ff, hex_in;
   logic                vld_ff, vld_in;
   logic [7:0]          char_ff, char_in;
   logic                last_ff, last_in;

   itad_ctl_type        ctl;
   itad_stat_type       stat;

   logic                slot_free;
   logic                accept;
   logic                neg_w, neg_n;
   logic [ValWidth-1:0] mag_w;
   logic [31:0]         mag_n;
   logic [ValWidth-1:0] dec_load;

   itad_digit_unit u_digits (
      .clock (clock),
      .ctl   (ctl),
      .stat  (stat)
   );

   assign slot_free = !vld_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // magnitude; the most negative value negates to itself as unsigned
   assign neg_w    = (req_action == ACT_SDEC) && req_value[ValWidth-1];
   assign neg_n    = (req_action == ACT_SDEC) && req_value[31];
   assign mag_w    = neg_w ? (~req_value + 64'd1) : req_value;
   assign mag_n    = neg_n ? (~req_value[31:0] + 32'd1) : req_value[31:0];
   // narrow operand sits in the top half so only 32 steps are needed
   assign dec_load = req_wide ? mag_w : {mag_n, 32'd0};

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cnt_in   = cnt_ff;
      keep_in  = keep_ff;
      neg_in   = neg_ff;
      hex_in   = hex_ff;
      vld_in   = vld_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      ctl.op   = CMD_HOLD;
      ctl.data = dec_load;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = CntWidth'(NumDigits);
               if (req_action == ACT_UDEC || req_action == ACT_SDEC) begin
                  ctl.op   = CMD_LOAD_DEC;
                  neg_in   = req_wide ? neg_w : neg_n;
                  hex_in   = 1'b0;
                  keep_in  = CntWidth'(1);
                  iter_in  = req_wide ? 6'd63 : 6'd31;
                  state_in = ST_CONV;
               end else begin
                  ctl.op   = CMD_LOAD_HEX;
                  ctl.data = req_wide ? req_value : {32'd0, req_value[31:0]};
                  neg_in   = 1'b0;
                  hex_in   = 1'b1;
                  keep_in  = (req_action == ACT_HEX16) ? CntWidth'(16) : CntWidth'(1);
                  state_in = ST_SKIP;
               end
            end
         end
         ST_CONV: begin
            ctl.op  = CMD_DABBLE;
            iter_in = iter_ff - 6'd1;
            if (iter_ff == '0) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (stat.top_zero && cnt_ff > keep_ff) begin
               ctl.op = CMD_SHIFT;
               cnt_in = cnt_ff - CntWidth'(1);
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               vld_in   = 1'b1;
               char_in  = CHAR_MINUS;
               last_in  = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               ctl.op  = CMD_SHIFT;
               vld_in  = 1'b1;
               char_in = digit_char(stat.top_digit);
               last_in = (cnt_ff == CntWidth'(1));
               cnt_in  = cnt_ff - CntWidth'(1);
               if (cnt_ff == CntWidth'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
      iter_ff <= iter_in;
      cnt_ff  <= cnt_in;
      keep_ff <= keep_in;
      neg_ff  <= neg_in;
      hex_ff  <= hex_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = vld_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

   // checks

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a number while another was still in work");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |-> cnt_ff != '0)
      else $error("digit count ran out before the final character");

   a_final_char: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && slot_free && cnt_ff == CntWidth'(1)
      |=> state_ff == ST_IDLE && rsp_valid && rsp_last_char)
      else $error("final character not flagged or sequencer not idle");

   a_decimal_digit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !hex_ff |-> stat.top_digit < 4'd10)
      else $error("decimal conversion produced a digit above nine");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// tb: self-checking testbench for integer_to_ascii_dec_hex, numbers in, ascii characters out
// depends on itad_pkg and integer_to_ascii_dec_hex; predicts each character and checks it in order
`default_nettype none

module tb;
   import itad_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CycleLimit   = 400000;
   localparam int          HoldCycles   = 300;
   localparam int          DrainCycles  = 150;
   localparam logic [7:0]  CharLowerA   = 8'h61;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } char_entry_type;

   // expected characters not yet seen, of every number taken so far, oldest first
   class char_scoreboard_type;
      char_entry_type pending[$];
      int             errors;

      function new();
         errors = 0;
      endfunction

      function logic [7:0] hex_char(input logic [3:0] d);
         logic [7:0] c;
         if (d < 4'd10) begin
            c = CHAR_ZERO + {4'd0, d};
         end else begin
            c = CharLowerA + {4'd0, d} - 8'd10;
         end
         return c;
      endfunction

      function void note_number(input logic [63:0] value, input logic [1:0] action,
                                input logic wide);
         logic [63:0]    mag;
         logic [31:0]    mag32;
         logic           neg;
         logic [7:0]     text[$];
         logic [7:0]     rev[$];
         int             ndig;
         char_entry_type e;
         neg = 1'b0;
         if (action == ACT_UDEC || action == ACT_SDEC) begin
            if (wide) begin
               mag = value;
               if (action == ACT_SDEC && value[63]) begin
                  neg = 1'b1;
                  mag = ~value + 64'd1;
               end
            end else begin
               mag = {32'd0, value[31:0]};
               if (action == ACT_SDEC && value[31]) begin
                  neg = 1'b1;
                  // negating the narrow minimum leaves 2^31, which is the magnitude wanted
                  mag32 = ~value[31:0] + 32'd1;
                  mag = {32'd0, mag32};
               end
            end
            do begin
               rev.push_back(CHAR_ZERO + 8'(mag % 64'd10));
               mag = mag / 64'd10;
            end while (mag != 64'd0);
            if (neg) begin
               text.push_back(CHAR_MINUS);
            end
            for (int k = rev.size() - 1; k >= 0; k--) begin
               text.push_back(rev[k]);
            end
         end else begin
            mag = wide ? value : {32'd0, value[31:0]};
            if (action == ACT_HEX16) begin
               ndig = 16;
            end else begin
               ndig = 1;
               while (ndig < 16 && (mag >> (ndig * 4)) != 64'd0) begin
                  ndig++;
               end
            end
            for (int k = ndig - 1; k >= 0; k--) begin
               text.push_back(hex_char(4'(mag >> (k * 4))));
            end
         end
         foreach (text[i]) begin
            e.ch   = text[i];
            e.last = (i == text.size() - 1);
            pending.push_back(e);
         end
      endfunction

      function void check_char(input logic [7:0] ch, input logic last);
         char_entry_type want;
         if (pending.size() == 0) begin
            $display("%0t: character with nothing expected: got char %h last %0b",
                     $time, ch, last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (ch !== want.ch) begin
            $display("%0t: out_char mismatch: expected %h, actual %h", $time, want.ch, ch);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_char mismatch: expected %0b, actual %0b",
                     $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [ValWidth-1:0] req_value;
   logic [1:0]          req_action;
   logic                req_wide;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [7:0]          rsp_out_char;
   logic                rsp_last_char;

   char_scoreboard_type sb;
   logic                steady;
   logic                hold_req;
   logic                hold_done;
   int                  hold_left;
   int                  cycles;

   logic [1:0] all_actions[4] = '{ACT_UDEC, ACT_SDEC, ACT_HEXMIN, ACT_HEX16};

   integer_to_ascii_dec_hex dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_action    (req_action),
      .req_wide      (req_wide),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random back-pressure plus one long hold-off
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = steady || ($urandom_range(99) >= 34);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_char(rsp_out_char, rsp_last_char);
      end
   end

   // entered and left at a falling edge; valid stays high into the next number unless an idle gap is drawn
   // idle gaps are of random length and need not outlast the conversion of the last number
   task automatic send_number(input logic [63:0] value, input logic [1:0] action,
                              input logic wide);
      req_value  = value;
      req_action = action;
      req_wide   = wide;
      req_valid  = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_number(value, action, wide);
      @(negedge clock);
      if (!steady && $urandom_range(99) < 34) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 60)) @(negedge clock);
      end
   endtask

   // operands of varied magnitude, sign-boundary values and junk in the upper half
   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      logic [63:0] full;
      full = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: v = full;
         1: v = 64'($urandom_range(0, 20));
         2: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         3: v = {1'b1, 63'd0} + 64'($urandom_range(0, 2)) - 64'd1;
         4: v = {full[63:32], 32'h8000_0000} + 64'($urandom_range(0, 2)) - 64'd1;
         5: v = full >> $urandom_range(0, 63);
         default: v = 64'd0 - 64'($urandom_range(1, 1000));
      endcase
      return v;
   endfunction

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         send_number(pick_value(), all_actions[$urandom_range(0, 3)], 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      sb         = new();
      cycles     = 0;
      steady     = 1'b0;
      hold_req   = 1'b0;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_value  = '0;
      req_action = ACT_UDEC;
      req_wide   = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // field extremes and the special cases
      send_number(64'd0, ACT_UDEC, 1'b1);
      send_number(64'hffff_ffff_ffff_ffff, ACT_UDEC, 1'b1);
      send_number(64'd10_000_000_000_000_000_000, ACT_UDEC, 1'b1);
      send_number(64'hdead_beef_ffff_ffff, ACT_UDEC, 1'b0);
      send_number(64'h8000_0000_0000_0000, ACT_SDEC, 1'b1);
      send_number(64'h7fff_ffff_ffff_ffff, ACT_SDEC, 1'b1);
      send_number(64'hffff_ffff_ffff_ffff, ACT_SDEC, 1'b1);
      send_number(64'd0, ACT_SDEC, 1'b1);
      send_number(64'h1234_5678_8000_0000, ACT_SDEC, 1'b0);
      send_number(64'hffff_ffff_7fff_ffff, ACT_SDEC, 1'b0);
      send_number(64'h0000_0000_ffff_ffff, ACT_SDEC, 1'b0);
      send_number(64'hffff_ffff_0000_0000, ACT_SDEC, 1'b0);
      send_number(64'd0, ACT_HEXMIN, 1'b1);
      send_number(64'hffff_ffff_ffff_ffff, ACT_HEXMIN, 1'b1);
      send_number(64'habcd_0000_0000_00f0, ACT_HEXMIN, 1'b0);
      send_number(64'h0123_4567_89ab_cdef, ACT_HEXMIN, 1'b1);
      send_number(64'd0, ACT_HEX16, 1'b1);
      send_number(64'hfedc_ba98_7654_3210, ACT_HEX16, 1'b1);
      send_number(64'h5555_aaaa_1234_5678, ACT_HEX16, 1'b0);
      send_number(64'hffff_ffff_ffff_ffff, ACT_HEX16, 1'b0);

      // stretch with no idling on either side
      steady = 1'b1;
      send_random(70);
      steady = 1'b0;

      // let everything drain before going on
      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat ($urandom_range(1, 5)) @(negedge clock);

      // receiver holds off for a while as numbers keep coming
      hold_req = 1'b1;
      send_random(180);

      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire
